[hdl/lphm_pkg.sv]
// lphm_pkg: shared widths, status codes and slot entry type for the linear probe hash map
// no dependencies; used by lphm_mod, lphm_table and linear_probe_hash_map
`timescale 1ns / 1ps

package lphm_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SIZE_W   = 11;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int BIT_CNT_W = $clog2(KEY_W + 1);

    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

endpackage

[hdl/lphm_mod.sv]
// lphm_mod: bit-serial restoring remainder unit, key modulo table size
// depends on lphm_pkg; one key bit per cycle
`timescale 1ns / 1ps

module lphm_mod
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lphm_pkg::KEY_W-1:0]   dividend,
    input  logic [lphm_pkg::SIZE_W-1:0]  divisor,
    output logic                         done,
    output logic [lphm_pkg::SIZE_W-1:0]  remainder
);

    logic [lphm_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [lphm_pkg::KEY_W-1:0]     shift_reg, shift_next;
    logic [lphm_pkg::SIZE_W-1:0]    rem_reg, rem_next;
    logic [lphm_pkg::SIZE_W-1:0]    div_reg, div_next;
    logic [lphm_pkg::SIZE_W:0]      trial;

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        trial      = {rem_reg, shift_reg[lphm_pkg::KEY_W-1]};
        if (start)
        begin
            cnt_next   = lphm_pkg::BIT_CNT_W'(lphm_pkg::KEY_W);
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so it fits back in SIZE_W bits
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = lphm_pkg::SIZE_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = lphm_pkg::SIZE_W'(trial);
            end
            shift_next = {shift_reg[lphm_pkg::KEY_W-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == lphm_pkg::BIT_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hdl/lphm_table.sv]
// lphm_table: slot memory holding used flag, key and value per slot
// depends on lphm_pkg; one write port, one registered read port
`timescale 1ns / 1ps

module lphm_table
(
    input  logic                        clk,
    input  lphm_pkg::wr_req_t           wr,
    input  logic                        rd_en,
    input  logic [lphm_pkg::IDX_W-1:0]  rd_addr,
    output lphm_pkg::entry_t            rd_data
);

    lphm_pkg::entry_t mem [lphm_pkg::CAPACITY];
    lphm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/linear_probe_hash_map.sv]
// linear_probe_hash_map: key-value table, open addressing with linear probing
// depends on lphm_pkg, lphm_mod (home slot remainder) and lphm_table (slot memory)
`timescale 1ns / 1ps

// usage:
// - config channel (cfg_valid/cfg_ready/cfg_data) writes the slot count; it is always
//   ready and should only be written while no operation is in flight
// - input channel (in_valid/in_stall, kind/key/value): kind 1 inserts or updates,
//   kind 0 looks up; in_stall is high while an operation is being worked on
// - output channel (out_valid/out_stall, status/read_value): one transaction per input
// - processing: the bit-serial key modulo, then a memory read and a compare for each
//   probed slot, then a load of the output register; the number of probes lies between
//   1 and the clamped slot count
// - the next item is accepted once the result sits in the output register, so a
//   stalled receiver holds the result while the following item is processed;
//   a second finished result waits inside until the output register frees up
// - reset: control clears at once, then a clearing pass marks all 1024 slots
//   empty, one slot a cycle; in_stall stays high during that pass
module linear_probe_hash_map
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lphm_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [lphm_pkg::KEY_W-1:0]          key,
    input  logic signed [lphm_pkg::VAL_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lphm_pkg::STAT_W-1:0]         status,
    output logic signed [lphm_pkg::VAL_W-1:0]   read_value
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [lphm_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [lphm_pkg::SIZE_W-1:0]    n_reg, n_next;
    logic [lphm_pkg::IDX_W-1:0]     pos_reg, pos_next;
    logic [lphm_pkg::SIZE_W-1:0]    probes_reg, probes_next;
    logic                           kind_reg, kind_next;
    logic [lphm_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [lphm_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [lphm_pkg::STAT_W-1:0]    res_stat_reg, res_stat_next;
    logic [lphm_pkg::VAL_W-1:0]     res_val_reg, res_val_next;
    logic                           out_valid_reg, out_valid_next;
    logic [lphm_pkg::STAT_W-1:0]    out_stat_reg, out_stat_next;
    logic [lphm_pkg::VAL_W-1:0]     out_val_reg, out_val_next;

    logic [lphm_pkg::SIZE_W-1:0]    n_eff;
    logic [lphm_pkg::SIZE_W-1:0]    probes_inc;
    logic [lphm_pkg::SIZE_W-1:0]    pos_inc;
    logic                           in_accept;
    logic                           mod_done;
    logic [lphm_pkg::SIZE_W-1:0]    mod_rem;
    logic                           rd_en;
    lphm_pkg::wr_req_t              wr;
    lphm_pkg::entry_t               rd_data;

    lphm_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (key),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lphm_table u_table
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    // clamp the configured size into 1..CAPACITY
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = lphm_pkg::SIZE_W'(1);
        end
        else if ({1'b0, size_reg} > (lphm_pkg::SIZE_W + 1)'(lphm_pkg::CAPACITY))
        begin
            n_eff = lphm_pkg::SIZE_W'(lphm_pkg::CAPACITY);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign probes_inc = probes_reg + 1'b1;
    assign pos_inc    = lphm_pkg::SIZE_W'(pos_reg) + 1'b1;
    assign rd_en      = (state_reg == S_READ);

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        probes_next    = probes_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        res_stat_next  = res_stat_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_val_next   = out_val_reg;
        wr.en          = 1'b0;
        wr.addr        = pos_reg;
        wr.data.used   = 1'b1;
        wr.data.key    = key_reg;
        wr.data.value  = val_reg;

        if (cfg_valid)
        begin
            size_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en         = 1'b1;
                wr.data.used  = 1'b0;
                wr.data.key   = '0;
                wr.data.value = '0;
                pos_next      = pos_reg + 1'b1;
                if (pos_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    val_next   = value;
                    n_next     = n_eff;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    pos_next    = lphm_pkg::IDX_W'(mod_rem);
                    probes_next = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_val_next = '0;
                if (!rd_data.used)
                begin
                    if (kind_reg)
                    begin
                        wr.en         = 1'b1;
                        res_stat_next = lphm_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        res_stat_next = lphm_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (rd_data.key == key_reg)
                begin
                    if (kind_reg)
                    begin
                        wr.en         = 1'b1;
                        res_stat_next = lphm_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        res_stat_next = lphm_pkg::ST_FOUND;
                        res_val_next  = rd_data.value;
                    end
                    state_next = S_DONE;
                end
                else if (probes_inc == n_reg)
                begin
                    // every slot in use visited without a hit
                    res_stat_next = kind_reg ? lphm_pkg::ST_FULL : lphm_pkg::ST_NOT_FOUND;
                    state_next    = S_DONE;
                end
                else
                begin
                    probes_next = probes_inc;
                    pos_next    = (pos_inc >= n_reg) ? '0 : lphm_pkg::IDX_W'(pos_inc);
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_val_next   = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            size_reg      <= lphm_pkg::SIZE_W'(1024);
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        probes_reg   <= probes_next;
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        res_stat_reg <= res_stat_next;
        res_val_reg  <= res_val_next;
        out_stat_reg <= out_stat_next;
        out_val_reg  <= out_val_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_stat_reg;
    assign read_value = out_val_reg;

endmodule

[tb/tb_linear_probe_hash_map.sv]
// tb_linear_probe_hash_map: self-checking bench for the linear probe hash map
// a scoreboard class mirrors the slot table and queues expected replies
// depends on lphm_pkg and linear_probe_hash_map
`timescale 1ns / 1ps

module tb_linear_probe_hash_map;

    typedef struct {
        logic [lphm_pkg::STAT_W-1:0]       status;
        logic signed [lphm_pkg::VAL_W-1:0] read_value;
    } reply_t;

    class hash_table_model;
        bit                          slot_used [lphm_pkg::CAPACITY];
        bit [lphm_pkg::KEY_W-1:0]    slot_key [lphm_pkg::CAPACITY];
        bit [lphm_pkg::VAL_W-1:0]    slot_value [lphm_pkg::CAPACITY];
        bit [lphm_pkg::SIZE_W-1:0]   size_setting;
        reply_t                      pending_replies [$];
        int                          errors;
        int                          replies_seen;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            size_setting = 11'd1024;
            errors       = 0;
            replies_seen = 0;
        endfunction

        // run one lookup or insert against the mirror table
        function void note_op(bit is_insert, bit [lphm_pkg::KEY_W-1:0] k,
                              bit [lphm_pkg::VAL_W-1:0] v);
            int unsigned n;
            int unsigned pos;
            int unsigned probes;
            bit          done;
            reply_t      r;
            n = size_setting;
            if (n < 1)
                n = 1;
            if (n > lphm_pkg::CAPACITY)
                n = lphm_pkg::CAPACITY;
            pos          = k % n;
            done         = 1'b0;
            r.status     = is_insert ? lphm_pkg::ST_FULL : lphm_pkg::ST_NOT_FOUND;
            r.read_value = '0;
            for (probes = 0; probes < n && !done; probes++)
            begin
                if (!slot_used[pos])
                begin
                    if (is_insert)
                    begin
                        slot_used[pos]  = 1'b1;
                        slot_key[pos]   = k;
                        slot_value[pos] = v;
                        r.status        = lphm_pkg::ST_INSERTED;
                    end
                    else
                        r.status = lphm_pkg::ST_NOT_FOUND;
                    done = 1'b1;
                end
                else if (slot_key[pos] == k)
                begin
                    if (is_insert)
                    begin
                        slot_value[pos] = v;
                        r.status        = lphm_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        r.status     = lphm_pkg::ST_FOUND;
                        r.read_value = slot_value[pos];
                    end
                    done = 1'b1;
                end
                else
                    pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [lphm_pkg::STAT_W-1:0] st,
                                  logic signed [lphm_pkg::VAL_W-1:0] rv);
            reply_t exp_r;
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: status %0d read_value %0d", st, rv);
                errors++;
                return;
            end
            exp_r = pending_replies.pop_front();
            if (st !== exp_r.status)
            begin
                $error("status mismatch: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (rv !== exp_r.read_value)
            begin
                $error("read_value mismatch: expected %0d, got %0d", exp_r.read_value, rv);
                errors++;
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [lphm_pkg::SIZE_W-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic                                kind;
    logic [lphm_pkg::KEY_W-1:0]          key;
    logic signed [lphm_pkg::VAL_W-1:0]   value;
    logic                                out_valid;
    logic                                out_stall;
    logic [lphm_pkg::STAT_W-1:0]         status;
    logic signed [lphm_pkg::VAL_W-1:0]   read_value;

    hash_table_model board = new();

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    linear_probe_hash_map dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value)
    );

    always #5 clk = ~clk;

    // mostly short gaps, some zero-length runs, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return $urandom_range(20, 70);
        if (pick < 7)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [lphm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic op_kind, input logic [lphm_pkg::KEY_W-1:0] k,
                           input logic [lphm_pkg::VAL_W-1:0] v);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op_kind;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        board.note_op(op_kind, k, v);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_table_size(input logic [lphm_pkg::SIZE_W-1:0] size);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid          <= 1'b0;
        board.size_setting  = size;
    endtask

    task automatic run_phase(input logic [lphm_pkg::SIZE_W-1:0] size, input int count);
        int unsigned                eff;
        int unsigned                pool_n;
        logic [lphm_pkg::KEY_W-1:0] pool [32];
        logic [lphm_pkg::KEY_W-1:0] k;
        logic                       op_kind;
        set_table_size(size);
        eff = (size == 0) ? 1 : (size > lphm_pkg::CAPACITY) ? lphm_pkg::CAPACITY : size;
        pool_n = (eff + 3 > 32) ? 32 : eff + 3;
        // about half the pool collides on purpose: small multiples of the size plus an offset
        for (int i = 0; i < pool_n; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                pool[i] = lphm_pkg::KEY_W'($urandom);
            else
                pool[i] = lphm_pkg::KEY_W'($urandom_range(0, 3) * eff
                                           + $urandom_range(0, eff - 1));
        end
        for (int i = 0; i < count; i++)
        begin
            op_kind = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_LOOKUP;
            if ($urandom_range(0, 9) == 0)
                k = lphm_pkg::KEY_W'($urandom);
            else
                k = pool[$urandom_range(0, pool_n - 1)];
            send_op(op_kind, k, pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_reply(status, read_value);
    end

    // receiver back-pressure, with one long hold-off so the block fills up
    initial
    begin
        int unsigned busy;
        int unsigned free;
        bit          held;
        out_stall = 1'b0;
        held      = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && board.replies_seen >= 150)
            begin
                held      = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            else
            begin
                busy = idle_len();
                free = idle_len();
                if (busy > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (busy) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat (free + 1) @(posedge clk);
        end
    end

    initial
    begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int drain;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = 1'b0;
        key       = '0;
        value     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset size, extremes, collisions and wrap-around
        send_op(KIND_LOOKUP, 31'd0, 32'h1234_5678);
        send_op(KIND_INSERT, 31'd0, 32'h8000_0000);
        send_op(KIND_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
        send_op(KIND_LOOKUP, 31'd0, 32'hffff_ffff);
        send_op(KIND_LOOKUP, 31'h7fff_ffff, 32'h0);
        send_op(KIND_INSERT, 31'd0, 32'h0);
        send_op(KIND_INSERT, 31'd1024, 32'hffff_ffff);
        send_op(KIND_LOOKUP, 31'd1024, 32'h0);
        send_op(KIND_LOOKUP, 31'd2048, 32'h0);
        // home slot is the last one, probe wraps to the front
        send_op(KIND_INSERT, 31'd1023, 32'd5);
        send_op(KIND_LOOKUP, 31'd1023, 32'h0);

        // one slot in use, already taken: a new key meets a full table, the stored key is found and updated
        set_table_size(11'd1);
        send_op(KIND_INSERT, 31'd5, 32'd77);
        send_op(KIND_LOOKUP, 31'd5, 32'h0);
        send_op(KIND_LOOKUP, 31'd0, 32'h0);
        send_op(KIND_INSERT, 31'd0, 32'h1234_5678);

        // zero size behaves as one slot
        set_table_size(11'd0);
        send_op(KIND_INSERT, 31'd9, 32'd1);
        send_op(KIND_LOOKUP, 31'd0, 32'h0);

        // oversized setting clamps to capacity, old entries still visible
        set_table_size(11'h7ff);
        send_op(KIND_LOOKUP, 31'd1023, 32'h0);
        send_op(KIND_LOOKUP, 31'h7fff_ffff, 32'h0);
        send_op(KIND_INSERT, 31'd2047, 32'h5555_aaaa);
        send_op(KIND_LOOKUP, 31'd2047, 32'h0);
        send_op(KIND_LOOKUP, 31'd3, 32'h0);

        run_phase(11'd4, 48);
        run_phase(11'd1, 30);
        run_phase(11'd9, 48);
        run_phase(11'd0, 30);
        run_phase(11'h7ff, 48);
        run_phase(11'd3, 48);
        run_phase(11'd16, 56);
        run_phase(11'd1024, 48);
        run_phase(11'd7, 48);
        run_phase(11'd2, 40);
        run_phase(11'd31, 64);
        run_phase(11'd5, 48);
        run_phase(11'd1025, 40);
        run_phase(11'd12, 48);

        in_valid <= 1'b0;
        for (drain = 0; drain < 20000 && board.pending_replies.size() != 0; drain++)
            @(posedge clk);
        if (board.pending_replies.size() != 0)
        begin
            $error("%0d expected replies never arrived", board.pending_replies.size());
            board.errors++;
        end
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hdl/lphm_pkg.sv
hdl/lphm_mod.sv
hdl/lphm_table.sv
hdl/linear_probe_hash_map.sv
tb/tb_linear_probe_hash_map.sv
